[hw/rtl/lsdrs_pkg.sv]
// ----------------------------------------------------------------------------
// LSD radix sort package
// Widths, digit geometry and the digit extraction function shared by the
// radix sort core.
// ----------------------------------------------------------------------------
package lsdrs_pkg;

  localparam int KEY_W         = 28;
  localparam int POS_W         = 6;
  localparam int DIGIT_W       = 4;
  localparam int DIGIT_BUCKETS = 16;
  localparam int ROUND_W       = 4;

  typedef logic [KEY_W-1:0]   key_t;
  typedef logic [DIGIT_W-1:0] digit_t;

  function automatic digit_t digit_of(input key_t key, input logic [ROUND_W-1:0] round);
    key_t shifted;
    shifted = key >> {round, 2'b00};
    return shifted[DIGIT_W-1:0];
  endfunction

endpackage

[hw/rtl/lsdrs_ram.sv]
// ----------------------------------------------------------------------------
// Generic simple dual-port RAM
// One write port and one read port with a registered read.
// ----------------------------------------------------------------------------
module lsdrs_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[hw/rtl/lsd_radix_sort_indices_core.sv]
// ----------------------------------------------------------------------------
// LSD radix sort of key indices
// Loads a set of keys, sorts them by a stable radix sort with 4-bit digits
// and returns the load position and key of every entry in ascending order.
// ----------------------------------------------------------------------------
// Keys are taken one per cycle until the key flagged last; after that the
// input stalls until the last result of the set has been transferred. For a
// set of n keys (n > 1) each of the ROUNDS rounds counts digits, turns the
// counts into offsets and scatters indices, using the single read port of
// the index memory. Each result then needs a dependent index read and key
// read, and waits out any output stall. A set larger than MAX_ITEMS keeps
// the first MAX_ITEMS keys and flags dropped on every result.
module lsd_radix_sort_indices_core
  import lsdrs_pkg::*;
#(
  parameter int MAX_ITEMS = 64,
  parameter int ROUNDS    = 7
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_stall,
  input  logic [KEY_W-1:0] in_key,
  input  logic             in_last_key,
  output logic             out_valid,
  input  logic             out_stall,
  output logic [POS_W-1:0] out_position,
  output logic [KEY_W-1:0] out_sorted_key,
  output logic             out_final_rank,
  output logic             out_dropped
);

  localparam int IW        = $clog2(MAX_ITEMS);
  localparam int NW        = $clog2(MAX_ITEMS + 1);
  localparam int RW        = (ROUNDS > 1) ? $clog2(ROUNDS) : 1;
  localparam int IDX_DEPTH = 2 * (1 << IW);

  typedef enum logic [2:0] {
    S_LOAD,
    S_START,
    S_COUNT,
    S_PREFIX,
    S_SCAT,
    S_OUT_IDX,
    S_OUT_KEY,
    S_OUT_SHOW
  } state_t;

  state_t           state_r;
  logic [NW-1:0]    loaded_r;
  logic             ovf_r;
  logic [NW-1:0]    i_r;
  logic             v1_r;
  logic             v2_r;
  logic [IW-1:0]    idx_d_r;
  logic [RW-1:0]    round_r;
  logic             bank_r;
  logic [DIGIT_W-1:0] b_r;
  logic [NW-1:0]    run_r;
  logic [IW-1:0]    pos_r;
  logic             out_valid_r;
  key_t             out_key_r;
  logic             out_final_r;
  logic             out_dropped_r;
  logic [NW-1:0]    cnt_r [DIGIT_BUCKETS];

  logic             in_xfer;
  logic             store;
  logic             in_pass;
  logic             issue;
  logic             pass_done;
  logic             last_round;
  logic             cnt_clr;
  digit_t           dig;
  logic [NW-1:0]    slot;

  logic             key_we;
  logic [IW-1:0]    key_raddr;
  key_t             key_rdata;
  logic             idx_we;
  logic [IW:0]      idx_waddr;
  logic [IW-1:0]    idx_wdata;
  logic [IW:0]      idx_raddr;
  logic [IW-1:0]    idx_rdata;

  assign in_stall   = (state_r != S_LOAD);
  assign in_xfer    = in_valid && !in_stall;
  assign store      = in_xfer && (loaded_r < NW'(MAX_ITEMS));
  assign in_pass    = (state_r == S_COUNT) || (state_r == S_SCAT);
  assign issue      = in_pass && (i_r < loaded_r);
  assign pass_done  = (i_r == loaded_r) && !v1_r && !v2_r;
  assign last_round = (round_r == RW'(ROUNDS - 1));
  assign cnt_clr    = (state_r == S_START) ||
                      ((state_r == S_SCAT) && pass_done && !last_round);
  assign dig        = digit_of(key_rdata, ROUND_W'(round_r));
  assign slot       = cnt_r[dig];

  assign key_we    = store;
  assign key_raddr = idx_rdata;
  assign idx_raddr = {bank_r, i_r[IW-1:0]};

  always_comb begin
    idx_we    = 1'b0;
    idx_waddr = {1'b0, loaded_r[IW-1:0]};
    idx_wdata = loaded_r[IW-1:0];
    if (store) begin
      idx_we = 1'b1;
    end else if ((state_r == S_SCAT) && v2_r) begin
      idx_we    = 1'b1;
      idx_waddr = {~bank_r, slot[IW-1:0]};
      idx_wdata = idx_d_r;
    end
  end

  lsdrs_ram #(
    .WIDTH(KEY_W),
    .DEPTH(MAX_ITEMS)
  ) u_key_ram (
    .clk  (clk),
    .we   (key_we),
    .waddr(loaded_r[IW-1:0]),
    .wdata(in_key),
    .raddr(key_raddr),
    .rdata(key_rdata)
  );

  lsdrs_ram #(
    .WIDTH(IW),
    .DEPTH(IDX_DEPTH)
  ) u_idx_ram (
    .clk  (clk),
    .we   (idx_we),
    .waddr(idx_waddr),
    .wdata(idx_wdata),
    .raddr(idx_raddr),
    .rdata(idx_rdata)
  );

  // Bucket counts double as running offsets during the scatter pass.
  always_ff @(posedge clk) begin
    if (cnt_clr) begin
      for (int k = 0; k < DIGIT_BUCKETS; k++) begin
        cnt_r[k] <= '0;
      end
    end else if (state_r == S_PREFIX) begin
      cnt_r[b_r] <= run_r;
    end else if (in_pass && v2_r) begin
      cnt_r[dig] <= slot + NW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_LOAD;
      loaded_r    <= '0;
      ovf_r       <= 1'b0;
      i_r         <= '0;
      v1_r        <= 1'b0;
      v2_r        <= 1'b0;
      round_r     <= '0;
      bank_r      <= 1'b0;
      b_r         <= '0;
      run_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      v1_r    <= issue;
      v2_r    <= v1_r;
      idx_d_r <= idx_rdata;
      if (issue) begin
        i_r <= i_r + NW'(1);
      end
      case (state_r)
        S_LOAD: begin
          if (in_xfer) begin
            if (store) begin
              loaded_r <= loaded_r + NW'(1);
            end else begin
              ovf_r <= 1'b1;
            end
            if (in_last_key) begin
              state_r <= S_START;
            end
          end
        end
        S_START: begin
          i_r     <= '0;
          round_r <= '0;
          bank_r  <= 1'b0;
          if (loaded_r == NW'(1)) begin
            state_r <= S_OUT_IDX;
          end else begin
            state_r <= S_COUNT;
          end
        end
        S_COUNT: begin
          if (pass_done) begin
            b_r     <= '0;
            run_r   <= '0;
            state_r <= S_PREFIX;
          end
        end
        S_PREFIX: begin
          run_r <= run_r + cnt_r[b_r];
          b_r   <= b_r + DIGIT_W'(1);
          if (b_r == DIGIT_W'(DIGIT_BUCKETS - 1)) begin
            i_r     <= '0;
            state_r <= S_SCAT;
          end
        end
        S_SCAT: begin
          if (pass_done) begin
            i_r    <= '0;
            bank_r <= ~bank_r;
            if (last_round) begin
              state_r <= S_OUT_IDX;
            end else begin
              round_r <= round_r + RW'(1);
              state_r <= S_COUNT;
            end
          end
        end
        S_OUT_IDX: begin
          state_r <= S_OUT_KEY;
        end
        S_OUT_KEY: begin
          pos_r   <= idx_rdata;
          state_r <= S_OUT_SHOW;
        end
        S_OUT_SHOW: begin
          if (!out_valid_r) begin
            out_valid_r   <= 1'b1;
            out_key_r     <= key_rdata;
            out_final_r   <= ((i_r + NW'(1)) == loaded_r);
            out_dropped_r <= ovf_r;
          end else if (!out_stall) begin
            out_valid_r <= 1'b0;
            if (out_final_r) begin
              loaded_r <= '0;
              ovf_r    <= 1'b0;
              state_r  <= S_LOAD;
            end else begin
              i_r     <= i_r + NW'(1);
              state_r <= S_OUT_IDX;
            end
          end
        end
        default: begin
          state_r <= S_LOAD;
        end
      endcase
    end
  end

  assign out_valid      = out_valid_r;
  assign out_position   = POS_W'(pos_r);
  assign out_sorted_key = out_key_r;
  assign out_final_rank = out_final_r;
  assign out_dropped    = out_dropped_r;

endmodule
